[hw/rtl/lrupr_pkg.sv]
// Package for the LRU page replacement block: field widths, reset values
// and a width helper. No dependencies.
package lrupr_pkg;

  // Width of the frames_in_use register and its value after reset.
  localparam int unsigned CfgW = 4;
  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  // Fixed widths of the result fields.
  localparam int unsigned SlotW = 3;
  localparam int unsigned EvictW = 16;

  // Defaults for the top level parameters.
  localparam int unsigned FramesDef = 8;
  localparam int unsigned PageBitsDef = 16;

  // Bits needed to index n entries, never less than one.
  function automatic int unsigned idx_w(input int unsigned n);
    idx_w = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[hw/rtl/lrupr_lookup.sv]
// Combinational frame search: hit detection, lowest empty frame and LRU victim.
// Depends on lrupr_pkg.
module lrupr_lookup #(
  parameter int unsigned FRAMES    = lrupr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = lrupr_pkg::PageBitsDef
) (
  input  logic [PAGE_BITS-1:0]                    page_i,
  input  logic [lrupr_pkg::CfgW-1:0]              cfg_frames_i,
  input  logic [PAGE_BITS-1:0]                    frame_page_i [FRAMES],
  input  logic [FRAMES-1:0]                       frame_valid_i,
  input  logic [lrupr_pkg::idx_w(FRAMES)-1:0]     frame_rank_i [FRAMES],
  output logic [FRAMES-1:0]                       active_o,
  output logic                                    hit_o,
  output logic [lrupr_pkg::idx_w(FRAMES)-1:0]     slot_o,
  output logic                                    slot_empty_o,
  output logic                                    evict_o,
  output logic [PAGE_BITS-1:0]                    evict_page_o
);
  import lrupr_pkg::*;

  localparam int unsigned IdxW = idx_w(FRAMES);

  logic [FRAMES-1:0] hit_vec;
  logic [FRAMES-1:0] empty_vec;
  logic [IdxW-1:0]   hit_idx;
  logic [IdxW-1:0]   empty_idx;
  logic [IdxW-1:0]   vic_idx;
  logic [IdxW-1:0]   vic_rank;
  logic              any_empty;

  // Frames taking part: a register value of zero still enables frame 0,
  // and values past the frame count cover all frames.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active_o[i]  = (i == 0) || (i < int'(cfg_frames_i));
      hit_vec[i]   = active_o[i] && frame_valid_i[i] && (frame_page_i[i] == page_i);
      empty_vec[i] = active_o[i] && !frame_valid_i[i];
    end
  end

  // Lowest matching frame and lowest empty frame.
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IdxW'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = IdxW'(i);
      end
    end
  end

  // Oldest participating frame; ties go to the lowest index.
  always_comb begin
    vic_idx  = '0;
    vic_rank = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (active_o[i] && (frame_rank_i[i] > vic_rank)) begin
        vic_rank = frame_rank_i[i];
        vic_idx  = IdxW'(i);
      end
    end
  end

  // Pick the slot: hit first, then an empty frame, then the victim.
  always_comb begin
    any_empty    = |empty_vec;
    hit_o        = |hit_vec;
    slot_empty_o = !hit_o && any_empty;
    evict_o      = !hit_o && !any_empty;
    if (hit_o) begin
      slot_o = hit_idx;
    end else if (any_empty) begin
      slot_o = empty_idx;
    end else begin
      slot_o = vic_idx;
    end
    evict_page_o = evict_o ? frame_page_i[vic_idx] : '0;
  end

endmodule

[hw/rtl/lrupr_frame_store.sv]
// Frame registers (page, valid, recency rank) and their per-reference update.
// Depends on lrupr_pkg.
module lrupr_frame_store #(
  parameter int unsigned FRAMES    = lrupr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = lrupr_pkg::PageBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                upd_en_i,
  input  logic [PAGE_BITS-1:0]                upd_page_i,
  input  logic                                upd_last_i,
  input  logic [lrupr_pkg::idx_w(FRAMES)-1:0] upd_slot_i,
  input  logic                                upd_slot_empty_i,
  input  logic [FRAMES-1:0]                   active_i,
  output logic [PAGE_BITS-1:0]                frame_page_o [FRAMES],
  output logic [FRAMES-1:0]                   frame_valid_o,
  output logic [lrupr_pkg::idx_w(FRAMES)-1:0] frame_rank_o [FRAMES]
);
  import lrupr_pkg::*;

  localparam int unsigned IdxW = idx_w(FRAMES);
  localparam logic [IdxW-1:0] RankMax = IdxW'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page_q  [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [FRAMES-1:0]    valid_d;
  logic [IdxW-1:0]      rank_q  [FRAMES];
  logic [IdxW-1:0]      rank_d  [FRAMES];
  logic [IdxW-1:0]      slot_rank;

  // Rank update: the touched frame becomes newest, younger valid frames
  // (all valid ones on an empty fill) that take part age by one and saturate
  // at the oldest rank. A closing reference empties every frame afterwards.
  always_comb begin
    valid_d   = valid_q;
    rank_d    = rank_q;
    slot_rank = rank_q[upd_slot_i];
    if (upd_en_i) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (IdxW'(i) == upd_slot_i) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end else if (active_i[i] && valid_q[i] &&
                     (upd_slot_empty_i || (rank_q[i] < slot_rank)) &&
                     (rank_q[i] != RankMax)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      if (upd_last_i) begin
        valid_d = '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_d[i] = '0;
        end
      end
    end
  end

  // Valid bits and ranks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // Page numbers are only read behind a valid bit, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      page_q[upd_slot_i] <= upd_page_i;
    end
  end

  assign frame_page_o  = page_q;
  assign frame_valid_o = valid_q;
  assign frame_rank_o  = rank_q;

endmodule

[hw/rtl/lru_page_replacement_top.sv]
// Top level of the fully associative LRU page replacement block: input
// register, configuration register, result register. Uses lrupr_pkg,
// lrupr_lookup and lrupr_frame_store.
//
//  Channel   Direction  Handshake                 Beat
//  request   in         start && !busy            page_number_i, last_in_sequence_i
//  result    out        done_o (one cycle)        hit_o, slot_o, evicted_valid_o,
//                                                 evicted_page_o
//  config    in         cfg_valid_i && cfg_ready_o cfg_data_i (frames_in_use)
//
// A request is registered at acceptance, looked up and applied to the frames
// in the next cycle, and its result is strobed in the cycle after that, with
// one request per cycle sustained. busy stays low, so a request may be started
// in every cycle; the frame compare and rank update fit between the input and
// result registers. The receiver cannot stall, so no result is ever held.
// Reset empties all frames and sets frames_in_use to 8.
module lru_page_replacement_top #(
  parameter int unsigned FRAMES    = lrupr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = lrupr_pkg::PageBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [PAGE_BITS-1:0]            page_number_i,
  input  logic                            last_in_sequence_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [lrupr_pkg::SlotW-1:0]     slot_o,
  output logic                            evicted_valid_o,
  output logic [lrupr_pkg::EvictW-1:0]    evicted_page_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrupr_pkg::CfgW-1:0]      cfg_data_i
);
  import lrupr_pkg::*;

  localparam int unsigned IdxW = idx_w(FRAMES);

  logic [CfgW-1:0]      cfg_frames_q;
  logic                 req_valid_q;
  logic [PAGE_BITS-1:0] req_page_q;
  logic                 req_last_q;

  logic [PAGE_BITS-1:0] frame_page  [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [IdxW-1:0]      frame_rank  [FRAMES];
  logic [FRAMES-1:0]    active;
  logic                 lk_hit;
  logic [IdxW-1:0]      lk_slot;
  logic                 lk_slot_empty;
  logic                 lk_evict;
  logic [PAGE_BITS-1:0] lk_evict_page;

  logic                 done_q;
  logic                 hit_q;
  logic [SlotW-1:0]     slot_q;
  logic                 ev_valid_q;
  logic [EvictW-1:0]    ev_page_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_frames_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_frames_q <= cfg_data_i;
    end
  end

  // Input register: one request beat per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_page_q <= page_number_i;
      req_last_q <= last_in_sequence_i;
    end
  end

  lrupr_lookup #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_lookup (
    .page_i        (req_page_q),
    .cfg_frames_i  (cfg_frames_q),
    .frame_page_i  (frame_page),
    .frame_valid_i (frame_valid),
    .frame_rank_i  (frame_rank),
    .active_o      (active),
    .hit_o         (lk_hit),
    .slot_o        (lk_slot),
    .slot_empty_o  (lk_slot_empty),
    .evict_o       (lk_evict),
    .evict_page_o  (lk_evict_page)
  );

  lrupr_frame_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_frame_store (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_en_i         (req_valid_q),
    .upd_page_i       (req_page_q),
    .upd_last_i       (req_last_q),
    .upd_slot_i       (lk_slot),
    .upd_slot_empty_i (lk_slot_empty),
    .active_i         (active),
    .frame_page_o     (frame_page),
    .frame_valid_o    (frame_valid),
    .frame_rank_o     (frame_rank)
  );

  // Result register and its strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      hit_q      <= lk_hit;
      slot_q     <= SlotW'(lk_slot);
      ev_valid_q <= lk_evict;
      ev_page_q  <= EvictW'(lk_evict_page);
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;

  // Every result beat comes from a request held in the cycle before.
  a_done_follows_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(req_valid_q))
    else $error("result strobe without a registered request");

  // A hit never evicts.
  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page reads as zero.
  a_evict_page_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without an eviction");

  // A closing reference leaves every frame empty.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && req_last_q) |=> (frame_valid == '0))
    else $error("frames still valid after the last reference");

endmodule
